// File: design/ugcd_pkg.sv
// Shared types and constants for the undirected graph cycle detector.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

package ugcd_pkg;

	// Width of a node id as it arrives on the request channel.
	localparam int ID_W = 8;

	// One request: an edge, an empty marker, or the closing item of a graph.
	typedef struct packed {
		logic [ID_W-1:0] edge_u;
		logic [ID_W-1:0] edge_v;
		logic            edge_valid;
		logic            last_edge;
	} item_t;

	// One result, given once per graph.
	typedef struct packed {
		logic has_cycle;
		logic overflow;
	} result_t;

endpackage

// File: design/ugcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for every store of the cycle detector.
`timescale 1ns / 1ps

module ugcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/undirected_graph_cycle_detect_unit.sv
// Top level of the undirected graph cycle detector: sequencer and stores.
// Depends on ugcd_pkg and ugcd_ram.
`timescale 1ns / 1ps

// Edges are loaded into per-node adjacency lists: the accepting cycle, then two head-list
// read/write pairs through the single head RAM port; the next request waits for both. A
// request with last_edge set starts a depth-first search with an explicit stack in RAM from
// every unvisited node 1..min(node_count, MAX_NODES-1); a scanned adjacency entry passes
// the top, entry and visit steps, plus a push step if it opens a new frame, a backtrack a
// top and a pop step, and a checked start node a read and a check step, plus a load step if
// it is unvisited, all paced by the registered RAM reads. One result (has_cycle, overflow)
// is given per graph. After reset and after every search, a clearing pass over all
// MAX_NODES entries empties the head lists and visit marks; no request is taken during the
// pass or the search, while configuration writes are always taken. Edges with an endpoint
// at or above MAX_NODES are dropped; edges beyond MAX_EDGES are dropped and raise overflow.
module undirected_graph_cycle_detect_unit #(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  ugcd_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output ugcd_pkg::result_t        result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ugcd_pkg::ID_W-1:0] cfg_data
);

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int SLOTS   = 2 * MAX_EDGES;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int PTR_W   = SLOT_W + 1;
	localparam int ET_W    = $clog2(MAX_EDGES + 1);
	localparam int SP_W    = $clog2(MAX_NODES + 1);
	localparam int ROOT_W  = ugcd_pkg::ID_W + 1;
	localparam int FRAME_W = 2 * NODE_W + 1 + PTR_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CLR      = 4'd1;
	localparam logic [3:0] S_L_RDU    = 4'd2;
	localparam logic [3:0] S_L_WRU    = 4'd3;
	localparam logic [3:0] S_L_RDV    = 4'd4;
	localparam logic [3:0] S_L_WRV    = 4'd5;
	localparam logic [3:0] S_ROOT_RD  = 4'd6;
	localparam logic [3:0] S_ROOT_CHK = 4'd7;
	localparam logic [3:0] S_ROOT_LD  = 4'd8;
	localparam logic [3:0] S_TOP      = 4'd9;
	localparam logic [3:0] S_POP      = 4'd10;
	localparam logic [3:0] S_EDGE     = 4'd11;
	localparam logic [3:0] S_VIS      = 4'd12;
	localparam logic [3:0] S_PUSH     = 4'd13;
	localparam logic [3:0] S_FIN      = 4'd14;

	localparam logic [PTR_W-1:0] PTR_NONE = {1'b1, {SLOT_W{1'b0}}};

	logic [3:0]                  state_q;
	logic [ugcd_pkg::ID_W-1:0]   node_count_q;
	logic [NODE_W-1:0]           u_q, v_q, clr_idx_q, nb_q;
	logic                        last_q, ovf_q, cyc_q;
	logic [ET_W-1:0]             edge_total_q;
	logic [ROOT_W-1:0]           root_q;
	logic [SP_W-1:0]             sp_q;
	logic [NODE_W-1:0]           top_node_q, top_from_q;
	logic                        top_has_from_q;
	logic [PTR_W-1:0]            top_cur_q;
	logic                        res_valid_q;
	ugcd_pkg::result_t           res_q;

	// RAM port signals.
	logic                        head_we, vis_we, adj_we, stk_we;
	logic [NODE_W-1:0]           head_waddr, head_raddr, vis_waddr, vis_raddr;
	logic [NODE_W-1:0]           stk_waddr, stk_raddr;
	logic [PTR_W-1:0]            head_wdata, head_rdata, next_rdata;
	logic                        vis_wdata, vis_rdata;
	logic [SLOT_W-1:0]           adj_waddr, adj_raddr;
	logic [NODE_W-1:0]           tgt_wdata, tgt_rdata;
	logic [FRAME_W-1:0]          stk_wdata, stk_rdata;

	logic                        accept, in_range, store_full, can_push, fin_go;
	logic [ROOT_W-1:0]           last_root;
	logic [SLOT_W-1:0]           slot_even;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Endpoint range, store capacity and search bounds.
	assign in_range   = (32'(item.edge_u) < MAX_NODES) && (32'(item.edge_v) < MAX_NODES);
	assign store_full = (32'(edge_total_q) >= MAX_EDGES);
	assign slot_even  = SLOT_W'({edge_total_q, 1'b0});
	assign last_root  = (32'(node_count_q) > MAX_NODES - 1) ? ROOT_W'(MAX_NODES - 1)
	                                                        : ROOT_W'(node_count_q);
	assign can_push   = (32'(sp_q) < MAX_NODES);
	assign fin_go     = !res_valid_q || !result_stall;

	// RAM address and write selection by sequencer state.
	always_comb begin
		head_we    = 1'b0;
		head_waddr = clr_idx_q;
		head_wdata = PTR_NONE;
		head_raddr = u_q;
		vis_we     = 1'b0;
		vis_waddr  = clr_idx_q;
		vis_wdata  = 1'b0;
		vis_raddr  = NODE_W'(root_q);
		adj_we     = 1'b0;
		adj_waddr  = slot_even;
		tgt_wdata  = v_q;
		adj_raddr  = top_cur_q[SLOT_W-1:0];
		stk_we     = 1'b0;
		stk_waddr  = NODE_W'(sp_q - SP_W'(1));
		stk_wdata  = {top_node_q, top_from_q, top_has_from_q, top_cur_q};
		stk_raddr  = NODE_W'(sp_q - SP_W'(2));
		unique case (state_q)
			S_CLR: begin
				head_we = 1'b1;
				vis_we  = 1'b1;
			end
			S_L_RDU: head_raddr = u_q;
			S_L_WRU: begin
				head_we    = 1'b1;
				head_waddr = u_q;
				head_wdata = {1'b0, slot_even};
				adj_we     = 1'b1;
			end
			S_L_RDV: head_raddr = v_q;
			S_L_WRV: begin
				head_we    = 1'b1;
				head_waddr = v_q;
				head_wdata = {1'b0, slot_even | SLOT_W'(1)};
				adj_we     = 1'b1;
				adj_waddr  = slot_even | SLOT_W'(1);
				tgt_wdata  = u_q;
			end
			S_ROOT_CHK: begin
				head_raddr = NODE_W'(root_q);
				vis_we     = !vis_rdata;
				vis_waddr  = NODE_W'(root_q);
				vis_wdata  = 1'b1;
			end
			S_EDGE: vis_raddr = tgt_rdata;
			S_VIS: begin
				head_raddr = nb_q;
				if (!vis_rdata && can_push) begin
					vis_we    = 1'b1;
					vis_waddr = nb_q;
					vis_wdata = 1'b1;
					stk_we    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer: clearing pass, edge loading and depth-first search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_idx_q    <= '0;
			node_count_q <= '0;
			edge_total_q <= '0;
			ovf_q        <= 1'b0;
			cyc_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			sp_q         <= '0;
			root_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			// The result is raised as the search finishes and dropped once taken.
			if (state_q == S_FIN && fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + NODE_W'(1);
					if (clr_idx_q == NODE_W'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						u_q    <= NODE_W'(item.edge_u);
						v_q    <= NODE_W'(item.edge_v);
						last_q <= item.last_edge;
						root_q <= ROOT_W'(1);
						cyc_q  <= 1'b0;
						if (item.edge_valid && in_range && !store_full) begin
							state_q <= S_L_RDU;
						end else begin
							if (item.edge_valid && in_range) begin
								ovf_q <= 1'b1;
							end
							if (item.last_edge) begin
								state_q <= S_ROOT_RD;
							end
						end
					end
				end
				S_L_RDU: state_q <= S_L_WRU;
				S_L_WRU: state_q <= S_L_RDV;
				S_L_RDV: state_q <= S_L_WRV;
				S_L_WRV: begin
					edge_total_q <= edge_total_q + ET_W'(1);
					state_q      <= last_q ? S_ROOT_RD : S_IDLE;
				end
				S_ROOT_RD: begin
					state_q <= (root_q > last_root) ? S_FIN : S_ROOT_CHK;
				end
				S_ROOT_CHK: begin
					if (vis_rdata) begin
						root_q  <= root_q + ROOT_W'(1);
						state_q <= S_ROOT_RD;
					end else begin
						state_q <= S_ROOT_LD;
					end
				end
				S_ROOT_LD: begin
					top_node_q     <= NODE_W'(root_q);
					top_from_q     <= '0;
					top_has_from_q <= 1'b0;
					top_cur_q      <= head_rdata;
					sp_q           <= SP_W'(1);
					state_q        <= S_TOP;
				end
				S_TOP: begin
					if (top_cur_q[SLOT_W]) begin
						sp_q <= sp_q - SP_W'(1);
						if (sp_q == SP_W'(1)) begin
							root_q  <= root_q + ROOT_W'(1);
							state_q <= S_ROOT_RD;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_POP: begin
					{top_node_q, top_from_q, top_has_from_q, top_cur_q} <= stk_rdata;
					state_q <= S_TOP;
				end
				S_EDGE: begin
					nb_q      <= tgt_rdata;
					top_cur_q <= next_rdata;
					state_q   <= S_VIS;
				end
				S_VIS: begin
					if (!vis_rdata) begin
						if (can_push) begin
							top_node_q     <= nb_q;
							top_from_q     <= top_node_q;
							top_has_from_q <= 1'b1;
							sp_q           <= sp_q + SP_W'(1);
							state_q        <= S_PUSH;
						end else begin
							state_q <= S_TOP;
						end
					end else if (!top_has_from_q || nb_q != top_from_q) begin
						cyc_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_PUSH: begin
					top_cur_q <= head_rdata;
					state_q   <= S_TOP;
				end
				S_FIN: begin
					if (fin_go) begin
						edge_total_q <= '0;
						ovf_q        <= 1'b0;
						clr_idx_q    <= '0;
						state_q      <= S_CLR;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// Result payload, written when the request leaves the search.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && fin_go) begin
			res_q.has_cycle <= cyc_q;
			res_q.overflow  <= ovf_q;
		end
	end

	// List heads, one per node.
	ugcd_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	// Neighbor of each adjacency entry.
	ugcd_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_target_ram (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(tgt_wdata),
		.raddr(adj_raddr), .rdata(tgt_rdata)
	);

	// Link to the following entry of the same list.
	ugcd_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_next_ram (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(head_rdata),
		.raddr(adj_raddr), .rdata(next_rdata)
	);

	// Visit marks.
	ugcd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit_ram (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rdata)
	);

	// Search frames below the top frame.
	ugcd_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// A result appears only when the search has finished.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the finish step");

	// The stack never runs past its depth.
	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= MAX_NODES)
		else $error("search stack exceeds its depth");

	// The edge count never exceeds the store.
	a_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(edge_total_q) <= MAX_EDGES)
		else $error("edge count beyond store capacity");

	// While a frame is scanned there is always at least one frame.
	a_top_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOP || state_q == S_EDGE || state_q == S_VIS) |-> sp_q != '0)
		else $error("frame scan with an empty stack");

endmodule
